@@ rtl/wsd_pkg.sv @@
// Shared types and constants for the WebSocket receive deframer.
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int LENGTH_BITS_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_PING_BITS   = 17;
    localparam logic [MAX_PING_BITS-1:0] MAX_PING_RESET = 17'h10000;

    localparam logic [3:0] OP_CONT       = 4'd0;
    localparam logic [3:0] OP_TEXT       = 4'd1;
    localparam logic [3:0] OP_BINARY     = 4'd2;
    localparam logic [3:0] OP_CONN_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING       = 4'd9;
    localparam logic [3:0] OP_PONG       = 4'd10;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [0:0] REG_MAX_PING = 1'b0;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT16,
        PH_EXT64,
        PH_DATA,
        PH_PING,
        PH_CLOSE,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        LS_OPEN,
        LS_CLOSED,
        LS_PROTO,
        LS_INTERNAL
    } t_link;

    typedef enum logic [2:0] {
        K_DATA,
        K_PING,
        K_REASON,
        K_DONE,
        K_CLOSED,
        K_PERR,
        K_IERR
    } t_kind;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_STICKY,
        EV_PERR,
        EV_IERR,
        EV_END,
        EV_START,
        EV_PAY
    } t_evt;

    typedef struct packed {
        logic        two;
        t_kind       kind0;
        logic [7:0]  byte0;
        t_kind       kind1;
        logic [3:0]  opcode;
        logic [15:0] close_code;
    } t_entry;

endpackage

@@ rtl/wsd_ifs.sv @@
// Stream channel interfaces for input bytes and result items.
`timescale 1ns / 1ps

interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface wsd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_kind;
    logic [7:0]  out_byte;
    logic [3:0]  frame_opcode;
    logic [15:0] close_code;
    logic        last;

    modport source (
        output valid, output out_kind, output out_byte, output frame_opcode,
        output close_code, output last, input ready
    );
    modport sink (
        input valid, input out_kind, input out_byte, input frame_opcode,
        input close_code, input last, output ready
    );
endinterface

@@ rtl/wsd_front.sv @@
// Front end: accepts stream bytes, parses frame headers and classifies each byte.
`timescale 1ns / 1ps

module wsd_front #(
    parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    wsd_in_if.sink                              i_in,
    input  logic [wsd_pkg::MAX_PING_BITS-1:0]   i_max_ping,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output wsd_pkg::t_entry                     o_q_data
);

    localparam int CW = (LENGTH_BITS > wsd_pkg::MAX_PING_BITS) ?
                        LENGTH_BITS : wsd_pkg::MAX_PING_BITS;
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;

    wsd_pkg::t_phase        r_phase, n_phase;
    wsd_pkg::t_link         r_status, n_status;
    logic [3:0]             r_opcode, n_opcode;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic [2:0]             r_cnt, n_cnt;
    logic                   r_top, n_top;
    logic                   r_ovf, n_ovf;
    logic [15:0]            r_cc, n_cc;
    logic [1:0]             r_cidx, n_cidx;

    logic                   w_accept;
    logic [7:0]             w_byte;
    logic                   w_hdr0_bad;
    logic                   w_is_ext;
    logic                   w_ext_last;
    logic [LENGTH_BITS-1:0] w_len_shift;
    logic [LENGTH_BITS-1:0] w_len_fin;
    logic                   w_hovf;
    logic                   w_ping_long;
    wsd_pkg::t_evt          w_hdr_evt;
    wsd_pkg::t_evt          w_evt;
    logic                   w_pay_end;
    logic                   w_pay_emit;
    wsd_pkg::t_kind         w_pay_kind;
    wsd_pkg::t_kind         w_end_kind;

    assign w_byte   = i_in.in_byte;
    assign i_in.ready = !i_q_full;
    assign w_accept = i_in.valid && !i_q_full;

    assign w_hdr0_bad = !w_byte[7] || (w_byte[6:4] != 3'd0) ||
                        !(w_byte[3:0] inside {wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT,
                          wsd_pkg::OP_BINARY, wsd_pkg::OP_CONN_CLOSE, wsd_pkg::OP_PING,
                          wsd_pkg::OP_PONG});
    assign w_is_ext   = (r_phase == wsd_pkg::PH_EXT16) || (r_phase == wsd_pkg::PH_EXT64);
    assign w_ext_last = ((r_phase == wsd_pkg::PH_EXT16) && (r_cnt == EXT16_LAST)) ||
                        ((r_phase == wsd_pkg::PH_EXT64) && (r_cnt == EXT64_LAST));
    assign w_len_shift = {r_len[LENGTH_BITS-9:0], w_byte};
    assign w_len_fin   = (r_phase == wsd_pkg::PH_HDR1) ?
                         LENGTH_BITS'(w_byte[6:0]) : w_len_shift;
    assign w_hovf      = w_is_ext && (r_ovf || (r_len[LENGTH_BITS-1 -: 8] != 8'd0));
    assign w_ping_long = CW'(w_len_fin) > CW'(i_max_ping);
    assign w_pay_end   = r_rem == LENGTH_BITS'(1);
    assign w_end_kind  = (r_opcode == wsd_pkg::OP_CONN_CLOSE) ? wsd_pkg::K_CLOSED
                                                              : wsd_pkg::K_DONE;

    always_comb begin
        if (w_hovf) begin
            w_hdr_evt = wsd_pkg::EV_IERR;
        end else if ((r_opcode == wsd_pkg::OP_PING) && w_ping_long) begin
            w_hdr_evt = wsd_pkg::EV_IERR;
        end else if ((r_opcode == wsd_pkg::OP_CONN_CLOSE) &&
                     (w_len_fin == LENGTH_BITS'(1))) begin
            w_hdr_evt = wsd_pkg::EV_PERR;
        end else if (w_len_fin == '0) begin
            w_hdr_evt = wsd_pkg::EV_END;
        end else begin
            w_hdr_evt = wsd_pkg::EV_START;
        end
    end

    always_comb begin
        w_evt = wsd_pkg::EV_NONE;
        if (r_status != wsd_pkg::LS_OPEN) begin
            w_evt = wsd_pkg::EV_STICKY;
        end else begin
            case (r_phase)
                wsd_pkg::PH_HDR0: begin
                    if (w_hdr0_bad) begin
                        w_evt = wsd_pkg::EV_PERR;
                    end
                end
                wsd_pkg::PH_HDR1: begin
                    if (w_byte[7]) begin
                        w_evt = wsd_pkg::EV_PERR;
                    end else if (!(w_byte[6:0] inside {wsd_pkg::LEN_EXT16,
                                                     wsd_pkg::LEN_EXT64})) begin
                        w_evt = w_hdr_evt;
                    end
                end
                wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
                    if (w_ext_last) begin
                        if ((r_phase == wsd_pkg::PH_EXT64) && r_top) begin
                            w_evt = wsd_pkg::EV_PERR;
                        end else begin
                            w_evt = w_hdr_evt;
                        end
                    end
                end
                default: begin
                    w_evt = wsd_pkg::EV_PAY;
                end
            endcase
        end
    end

    always_comb begin
        w_pay_emit = 1'b0;
        w_pay_kind = wsd_pkg::K_DATA;
        case (r_phase)
            wsd_pkg::PH_DATA: begin
                w_pay_emit = 1'b1;
            end
            wsd_pkg::PH_PING: begin
                w_pay_emit = 1'b1;
                w_pay_kind = wsd_pkg::K_PING;
            end
            wsd_pkg::PH_CLOSE: begin
                w_pay_emit = r_cidx == 2'd2;
                w_pay_kind = wsd_pkg::K_REASON;
            end
            default: begin
                w_pay_emit = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_phase  = r_phase;
        n_status = r_status;
        n_opcode = r_opcode;
        n_len    = r_len;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_top    = r_top;
        n_ovf    = r_ovf;
        n_cc     = r_cc;
        n_cidx   = r_cidx;
        if (w_accept && (r_status == wsd_pkg::LS_OPEN)) begin
            case (r_phase)
                wsd_pkg::PH_HDR0: begin
                    n_opcode = w_byte[3:0];
                    n_phase  = wsd_pkg::PH_HDR1;
                end
                wsd_pkg::PH_HDR1: begin
                    if (w_byte[6:0] == wsd_pkg::LEN_EXT64) begin
                        n_len   = '0;
                        n_cnt   = 3'd0;
                        n_ovf   = 1'b0;
                        n_phase = wsd_pkg::PH_EXT64;
                    end else if (w_byte[6:0] == wsd_pkg::LEN_EXT16) begin
                        n_len   = '0;
                        n_cnt   = 3'd0;
                        n_ovf   = 1'b0;
                        n_phase = wsd_pkg::PH_EXT16;
                    end else begin
                        n_len = w_len_fin;
                    end
                end
                wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
                    n_len = w_len_shift;
                    n_ovf = w_hovf;
                    if (r_cnt == 3'd0) begin
                        n_top = w_byte[7];
                    end
                    n_cnt = w_ext_last ? 3'd0 : r_cnt + 3'd1;
                end
                default: begin
                    n_rem = r_rem - LENGTH_BITS'(1);
                    if (r_phase == wsd_pkg::PH_CLOSE) begin
                        if (r_cidx == 2'd0) begin
                            n_cc = {w_byte, 8'h00};
                        end else if (r_cidx == 2'd1) begin
                            n_cc = r_cc | {8'h00, w_byte};
                        end
                        if (r_cidx != 2'd2) begin
                            n_cidx = r_cidx + 2'd1;
                        end
                    end
                    if (w_pay_end) begin
                        n_phase = wsd_pkg::PH_HDR0;
                        if (r_opcode == wsd_pkg::OP_CONN_CLOSE) begin
                            n_status = wsd_pkg::LS_CLOSED;
                        end
                    end
                end
            endcase

            if (((w_evt == wsd_pkg::EV_PERR) && (r_phase != wsd_pkg::PH_HDR0) &&
                 (r_phase != wsd_pkg::PH_HDR1 || !w_byte[7]) &&
                 !(r_phase == wsd_pkg::PH_EXT64 && r_top)) ||
                (w_evt == wsd_pkg::EV_END) || (w_evt == wsd_pkg::EV_START)) begin
                if (r_opcode == wsd_pkg::OP_CONN_CLOSE) begin
                    n_cc = 16'd0;
                end
            end

            case (w_evt)
                wsd_pkg::EV_PERR: begin
                    n_status = wsd_pkg::LS_PROTO;
                end
                wsd_pkg::EV_IERR: begin
                    n_status = wsd_pkg::LS_INTERNAL;
                end
                wsd_pkg::EV_END: begin
                    n_phase = wsd_pkg::PH_HDR0;
                    if (r_opcode == wsd_pkg::OP_CONN_CLOSE) begin
                        n_status = wsd_pkg::LS_CLOSED;
                    end
                end
                wsd_pkg::EV_START: begin
                    n_rem  = w_len_fin;
                    n_cidx = 2'd0;
                    case (r_opcode)
                        wsd_pkg::OP_BINARY:     n_phase = wsd_pkg::PH_DATA;
                        wsd_pkg::OP_PING:       n_phase = wsd_pkg::PH_PING;
                        wsd_pkg::OP_CONN_CLOSE: n_phase = wsd_pkg::PH_CLOSE;
                        default:                n_phase = wsd_pkg::PH_SKIP;
                    endcase
                end
                default: begin
                    n_rem = n_rem;
                end
            endcase
        end
    end

    // Queue entry for the results of this byte
    always_comb begin
        o_q_push            = 1'b0;
        o_q_data.two        = 1'b0;
        o_q_data.kind0      = wsd_pkg::K_DONE;
        o_q_data.byte0      = 8'd0;
        o_q_data.kind1      = w_end_kind;
        o_q_data.opcode     = n_opcode;
        o_q_data.close_code = n_cc;
        case (w_evt)
            wsd_pkg::EV_STICKY: begin
                o_q_push = w_accept;
                case (r_status)
                    wsd_pkg::LS_CLOSED: o_q_data.kind0 = wsd_pkg::K_CLOSED;
                    wsd_pkg::LS_PROTO:  o_q_data.kind0 = wsd_pkg::K_PERR;
                    default:            o_q_data.kind0 = wsd_pkg::K_IERR;
                endcase
            end
            wsd_pkg::EV_PERR: begin
                o_q_push       = w_accept;
                o_q_data.kind0 = wsd_pkg::K_PERR;
            end
            wsd_pkg::EV_IERR: begin
                o_q_push       = w_accept;
                o_q_data.kind0 = wsd_pkg::K_IERR;
            end
            wsd_pkg::EV_END: begin
                o_q_push       = w_accept;
                o_q_data.kind0 = w_end_kind;
            end
            wsd_pkg::EV_PAY: begin
                if (w_pay_emit) begin
                    o_q_push       = w_accept;
                    o_q_data.kind0 = w_pay_kind;
                    o_q_data.byte0 = w_byte;
                    o_q_data.two   = w_pay_end;
                end else begin
                    o_q_push       = w_accept && w_pay_end;
                    o_q_data.kind0 = w_end_kind;
                end
            end
            default: begin
                o_q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsd_pkg::PH_HDR0;
            r_status <= wsd_pkg::LS_OPEN;
            r_opcode <= 4'd0;
            r_len    <= '0;
            r_rem    <= '0;
            r_cnt    <= 3'd0;
            r_top    <= 1'b0;
            r_ovf    <= 1'b0;
            r_cc     <= 16'd0;
            r_cidx   <= 2'd0;
        end else begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_opcode <= n_opcode;
            r_len    <= n_len;
            r_rem    <= n_rem;
            r_cnt    <= n_cnt;
            r_top    <= n_top;
            r_ovf    <= n_ovf;
            r_cc     <= n_cc;
            r_cidx   <= n_cidx;
        end
    end

endmodule

@@ rtl/wsd_queue.sv @@
// Short queue of classified entries between the front and back ends.
`timescale 1ns / 1ps

module wsd_queue #(
    parameter int DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wsd_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output wsd_pkg::t_entry o_data,
    output logic            o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    wsd_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_full  = r_cnt == CNTW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CNTW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ rtl/wsd_back.sv @@
// Back end: expands queue entries into result items in an output register.
`timescale 1ns / 1ps

module wsd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wsd_pkg::t_entry i_q_data,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    wsd_out_if.source       o_out
);

    logic           r_valid, n_valid;
    logic           r_sub, n_sub;
    wsd_pkg::t_kind r_kind, n_kind;
    logic [7:0]     r_byte, n_byte;
    logic [3:0]     r_opcode, n_opcode;
    logic [15:0]    r_cc, n_cc;
    logic           r_last, n_last;
    logic           w_load;

    assign w_load = !r_valid || o_out.ready;

    always_comb begin
        n_valid  = r_valid;
        n_sub    = r_sub;
        n_kind   = r_kind;
        n_byte   = r_byte;
        n_opcode = r_opcode;
        n_cc     = r_cc;
        n_last   = r_last;
        o_q_pop  = 1'b0;
        if (w_load) begin
            if (i_q_empty) begin
                n_valid = 1'b0;
            end else begin
                n_valid  = 1'b1;
                n_opcode = i_q_data.opcode;
                if (i_q_data.two && !r_sub) begin
                    n_kind = i_q_data.kind0;
                    n_byte = i_q_data.byte0;
                    n_last = 1'b0;
                    n_sub  = 1'b1;
                end else if (i_q_data.two) begin
                    n_kind  = i_q_data.kind1;
                    n_byte  = 8'd0;
                    n_last  = 1'b1;
                    n_sub   = 1'b0;
                    o_q_pop = 1'b1;
                end else begin
                    n_kind  = i_q_data.kind0;
                    n_byte  = i_q_data.byte0;
                    n_last  = 1'b1;
                    o_q_pop = 1'b1;
                end
                n_cc = (n_kind == wsd_pkg::K_CLOSED) ? i_q_data.close_code : 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_byte   <= n_byte;
        r_opcode <= n_opcode;
        r_cc     <= n_cc;
        r_last   <= n_last;
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_kind     = r_kind;
    assign o_out.out_byte     = r_byte;
    assign o_out.frame_opcode = r_opcode;
    assign o_out.close_code   = r_cc;
    assign o_out.last         = r_last;

endmodule

@@ rtl/websocket_rx_frame_deframer.sv @@
// Top level of the WebSocket receive deframer with its register port.
//
//   Channel   Direction  Carries
//   i_in      sink       one received stream byte per transfer
//   o_out     source     one result item per transfer (kind, byte, opcode, code, last)
//   APB       slave      max_ping_length at byte address 0
//
// While the queue has room, one byte is taken per cycle and parsed in that cycle.
// A byte that both carries payload and ends the frame gives two results, and
// the output register sends one result per cycle unless o_out.ready stalls it,
// so such a byte takes two output transfers; a QUEUE_DEPTH-entry queue (four
// by default) sits between the two ends. i_in.ready is low only while it is full.
// Reset is synchronous.
`timescale 1ns / 1ps

module websocket_rx_frame_deframer #(
    parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsd_in_if.sink      i_in,
    wsd_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [wsd_pkg::MAX_PING_BITS-1:0] r_max_ping;
    logic            w_q_push;
    logic            w_q_full;
    logic            w_q_pop;
    logic            w_q_empty;
    wsd_pkg::t_entry w_q_wdata;
    wsd_pkg::t_entry w_q_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == wsd_pkg::REG_MAX_PING) ?
                    32'(r_max_ping) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ping <= wsd_pkg::MAX_PING_RESET;
        end else if (psel && penable && pwrite &&
                     (paddr[2] == wsd_pkg::REG_MAX_PING)) begin
            r_max_ping <= pwdata[wsd_pkg::MAX_PING_BITS-1:0];
        end
    end

    wsd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_max_ping (r_max_ping),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_wdata)
    );

    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty)
    );

    wsd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (w_q_rdata),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .o_out     (o_out)
    );

endmodule
